// ===== sv/elip_pkg.sv =====
// Shared types and constants of the earth-orientation interpolator.
// No dependencies; used by every module of the block except elip_ram.
package elip_pkg;

   localparam int TIME_W    = 40;
   localparam int VAL_W     = 32;
   localparam int ITEM_W    = TIME_W + 3 * VAL_W;
   localparam int MAG_W     = 41;
   localparam int WGT_W     = 63;
   localparam int PROD_W    = 104;
   localparam int PP_W      = 64;
   localparam int ACC_W     = 100;
   localparam int DIV_STEPS = 62;
   localparam int DCNT_W    = 6;

   localparam logic [WGT_W-1:0] W_ONE = 63'h0000_0001_0000_0000;
   localparam logic [WGT_W-1:0] W_MAX = 63'h4000_0000_0000_0000;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;

   typedef enum logic [2:0] {
      ST_INTERP  = 3'd0,
      ST_HELD    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_STORED  = 3'd3,
      ST_FULL    = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      MS_WL_NL, MS_WL_NH, MS_WH_NL, MS_WH_NH,
      MS_WL_Y0, MS_WH_Y0, MS_WL_Y1, MS_WH_Y1, MS_WL_Y2, MS_WH_Y2
   } mul_sel_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_CAPTURE, DP_WRITE, DP_RES_STATUS, DP_RES_HELD, DP_RES_MATCH,
      DP_RES_INTERP, DP_SCAN, DP_NODE, DP_FACTOR, DP_MUL, DP_SATCHK, DP_DIV
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type sel;
      status_type  status;
      logic        publish;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       scan_hit;
      logic       time_eq;
      logic       den_zero;
      logic       sat;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE, S_EXEC, S_SCAN_RD, S_SCAN_CK, S_WIN, S_MATCH_RD, S_MATCH_CK,
      S_NODE_RD, S_NODE_LD, S_FAC_RD, S_FAC_LD, S_FAC_CHK, S_MUL, S_MUL_END,
      S_SAT, S_DIV, S_FAC_NEXT, S_TERM, S_TERM_END, S_NODE_NEXT, S_FINISH, S_FIN
   } ctrl_state_type;

endpackage

// ===== sv/eop_lagrange_interpolator.sv =====
// Top level of the earth-orientation table with Lagrange interpolation.
// Depends on elip_pkg, elip_ctrl, elip_dp (which holds elip_ram).
//
// Usage: one request channel (req_*) and one response channel (rsp_*).
// req_tuser carries the opcode (clear, append, query; opcode three queries).
// Every request transfer yields exactly one response transfer, in order.
// Clear and append pass through S_EXEC and S_FIN before the response is valid.
// A query works on a window of W nodes (W <= 2*HALF_WINDOW+1). Its run time
// is set by the bit-serial divider and by the shared 32x32 multiplier, which
// makes 4 passes per Lagrange factor and 6 per node.
// One request is worked on at a time; req_tready is high only while the
// sequencer is idle, and a new request is taken while the previous response
// still waits in the output register. When the receiver stalls, the
// finished result is held until the output register frees.
// Reset empties the table (entry count zero) and drops any pending response;
// table contents are not cleared and are never read before being written.
module eop_lagrange_interpolator #(
   parameter int TABLE_DEPTH = 64,
   parameter int HALF_WINDOW = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,  // opcode
   input  logic [elip_pkg::ITEM_W-1:0] req_tdata,  // time_tai, in_pole_x,
                                                   // in_pole_y, in_ut1_offset
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2:0]                  rsp_tuser,  // status
   output logic [elip_pkg::ITEM_W-1:0] rsp_tdata   // out_time, out_pole_x,
                                                   // out_pole_y, out_ut1_offset
);
   import elip_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   dp_cmd_type    cmd;
   dp_stat_type   stat;
   logic [AW-1:0] addr_a, addr_b, addr_w;

   elip_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .HALF_WINDOW(HALF_WINDOW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .addr_a     (addr_a),
      .addr_b     (addr_b),
      .addr_w     (addr_w)
   );

   elip_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .addr_w    (addr_w),
      .stat      (stat),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== sv/elip_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module elip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== sv/elip_ctrl.sv =====
// Sequencer of the interpolator: table count, scan, window and loop counters.
// Depends on elip_pkg; drives elip_dp through command and status structs.
module elip_ctrl #(
   parameter int TABLE_DEPTH = 64,
   parameter int HALF_WINDOW = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  elip_pkg::dp_stat_type          stat,
   output elip_pkg::dp_cmd_type           cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0] addr_a,
   output logic [$clog2(TABLE_DEPTH)-1:0] addr_b,
   output logic [$clog2(TABLE_DEPTH)-1:0] addr_w
);
   import elip_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int WW = AW + 5;

   ctrl_state_type    state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     i_ff, i_in, j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]     begin_ff, begin_in;
   logic              begin_vld_ff, begin_vld_in;
   logic [2:0]        m_ff, m_in;
   logic [DCNT_W-1:0] d_ff, d_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic [AW-1:0] last_idx;
   logic [WW-1:0] b1, lo_w, hi_w;
   logic          found_now;

   assign last_idx  = AW'(count_ff - CW'(1));
   assign b1        = WW'(begin_ff) + WW'(1);
   assign lo_w      = (b1 >= WW'(HALF_WINDOW)) ? b1 - WW'(HALF_WINDOW) : '0;
   assign hi_w      = (b1 + WW'(HALF_WINDOW) > WW'(last_idx)) ? WW'(last_idx)
                                                             : b1 + WW'(HALF_WINDOW);
   assign found_now = (i_ff != '0) && stat.scan_hit;

   assign addr_a     = i_ff;
   assign addr_b     = j_ff;
   assign addr_w     = count_ff[AW-1:0];
   assign rsp_tvalid = rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         begin_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         begin_vld_ff <= begin_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      begin_ff <= begin_in;
      m_ff     <= m_in;
      d_ff     <= d_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      begin_in     = begin_ff;
      begin_vld_in = begin_vld_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = DP_NOP;
      cmd.sel      = MS_WL_NL;
      cmd.status   = ST_INTERP;
      cmd.publish  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = DP_CAPTURE;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (stat.opcode)
               OP_CLEAR: begin
                  count_in   = '0;
                  cmd.op     = DP_RES_STATUS;
                  cmd.status = ST_CLEARED;
               end
               OP_APPEND: begin
                  if (count_ff < CW'(TABLE_DEPTH)) begin
                     cmd.op   = DP_WRITE;
                     count_in = count_ff + CW'(1);
                  end else begin
                     cmd.op     = DP_RES_STATUS;
                     cmd.status = ST_FULL;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     cmd.op     = DP_RES_STATUS;
                     cmd.status = ST_EMPTY;
                  end else begin
                     i_in         = '0;
                     begin_vld_in = 1'b0;
                     state_in     = S_SCAN_RD;
                  end
               end
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_CK;
         S_SCAN_CK: begin
            cmd.op = DP_SCAN;
            if (found_now) begin
               begin_in     = i_ff - AW'(1);
               begin_vld_in = 1'b1;
            end
            if (i_ff == last_idx) begin
               if (found_now || begin_vld_ff) begin
                  state_in = S_WIN;
               end else begin
                  cmd.op   = DP_RES_HELD;
                  state_in = S_FIN;
               end
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_WIN: begin
            lo_in    = lo_w[AW-1:0];
            hi_in    = hi_w[AW-1:0];
            i_in     = lo_w[AW-1:0];
            state_in = S_MATCH_RD;
         end
         S_MATCH_RD: state_in = S_MATCH_CK;
         S_MATCH_CK: begin
            if (stat.time_eq) begin
               cmd.op   = DP_RES_MATCH;
               state_in = S_FIN;
            end else if (i_ff == hi_ff) begin
               i_in     = lo_ff;
               state_in = S_NODE_RD;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_MATCH_RD;
            end
         end
         S_NODE_RD: state_in = S_NODE_LD;
         S_NODE_LD: begin
            cmd.op   = DP_NODE;
            j_in     = lo_ff;
            state_in = S_FAC_RD;
         end
         S_FAC_RD: state_in = (j_ff == i_ff) ? S_FAC_NEXT : S_FAC_LD;
         S_FAC_LD: begin
            cmd.op   = DP_FACTOR;
            state_in = S_FAC_CHK;
         end
         S_FAC_CHK: begin
            m_in     = '0;
            state_in = stat.den_zero ? S_FAC_NEXT : S_MUL;
         end
         S_MUL: begin
            cmd.op = DP_MUL;
            case (m_ff)
               3'd0:    cmd.sel = MS_WL_NL;
               3'd1:    cmd.sel = MS_WL_NH;
               3'd2:    cmd.sel = MS_WH_NL;
               default: cmd.sel = MS_WH_NH;
            endcase
            m_in = m_ff + 3'd1;
            if (m_ff == 3'd3) begin
               state_in = S_MUL_END;
            end
         end
         S_MUL_END: state_in = S_SAT;
         S_SAT: begin
            cmd.op   = DP_SATCHK;
            d_in     = '0;
            state_in = stat.sat ? S_FAC_NEXT : S_DIV;
         end
         S_DIV: begin
            cmd.op = DP_DIV;
            d_in   = d_ff + DCNT_W'(1);
            if (d_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FAC_NEXT;
            end
         end
         S_FAC_NEXT: begin
            if (j_ff == hi_ff) begin
               m_in     = '0;
               state_in = S_TERM;
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = S_FAC_RD;
            end
         end
         S_TERM: begin
            cmd.op = DP_MUL;
            case (m_ff)
               3'd0:    cmd.sel = MS_WL_Y0;
               3'd1:    cmd.sel = MS_WH_Y0;
               3'd2:    cmd.sel = MS_WL_Y1;
               3'd3:    cmd.sel = MS_WH_Y1;
               3'd4:    cmd.sel = MS_WL_Y2;
               default: cmd.sel = MS_WH_Y2;
            endcase
            m_in = m_ff + 3'd1;
            if (m_ff == 3'd5) begin
               state_in = S_TERM_END;
            end
         end
         S_TERM_END: state_in = S_NODE_NEXT;
         S_NODE_NEXT: begin
            if (i_ff == hi_ff) begin
               state_in = S_FINISH;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_NODE_RD;
            end
         end
         S_FINISH: begin
            cmd.op   = DP_RES_INTERP;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_vld_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               rsp_vld_in  = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== sv/elip_dp.sv =====
// Datapath: entry table, shared 32x32 multiplier, bit-serial divider,
// accumulators and result/output registers. Depends on elip_pkg, elip_ram.
module elip_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_tuser,
   input  logic [elip_pkg::ITEM_W-1:0]    req_tdata,
   input  elip_pkg::dp_cmd_type           cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0] addr_a,
   input  logic [$clog2(TABLE_DEPTH)-1:0] addr_b,
   input  logic [$clog2(TABLE_DEPTH)-1:0] addr_w,
   output elip_pkg::dp_stat_type          stat,
   output logic [2:0]                     rsp_tuser,
   output logic [elip_pkg::ITEM_W-1:0]    rsp_tdata
);
   import elip_pkg::*;

   function automatic logic [VAL_W-1:0] finish_val(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-1:0] a;
      a = acc + ACC_W'(64'h8000_0000);
      if ((&a[ACC_W-1:63]) || !(|a[ACC_W-1:63])) begin
         return a[63:32];
      end
      return a[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   function automatic logic [6:0] shift_of(input mul_sel_type s);
      case (s)
         MS_WL_NH, MS_WH_NL, MS_WH_Y0, MS_WH_Y1, MS_WH_Y2: return 7'd32;
         MS_WH_NH: return 7'd64;
         default:  return 7'd0;
      endcase
   endfunction

   // packed entry, lowest bits first: ut1, pole y, pole x, time
   logic [ITEM_W-1:0] rd_a, rd_b, wr_data;
   logic              we;

   elip_ram #(.WIDTH(ITEM_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock     (clock),
      .we        (we),
      .wr_addr   (addr_w),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (addr_b),
      .rd_data_b (rd_b)
   );

   logic [1:0]               op_ff;
   logic signed [TIME_W-1:0] t_ff, prev_ff, xi_ff;
   logic [3*VAL_W-1:0]       item_ff;
   logic signed [VAL_W-1:0]  yv_ff [3];
   logic [WGT_W-1:0]         w_ff, w_in;
   logic                     neg_ff, neg_in, nsign_ff, dsign_ff;
   logic [MAG_W-1:0]         nmag_ff, dmag_ff, rem_ff, rem_in;
   logic [PROD_W-1:0]        p_ff, p_in;
   logic [PP_W-1:0]          pp_ff;
   mul_sel_type              pp_sel_ff;
   logic                     pp_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic signed [ACC_W-1:0]  acc_in [3];
   status_type               res_status_ff, rsp_status_ff;
   logic [ITEM_W-1:0]        res_data_ff, rsp_data_ff;

   logic signed [TIME_W-1:0] a_time, b_time;
   logic signed [MAG_W-1:0]  num, den;
   logic [VAL_W-1:0]         mul_a, mul_b;
   logic [6:0]               pp_sh;
   logic [ACC_W-1:0]         term;
   logic [1:0]               acc_k;
   logic                     is_term;
   logic [MAG_W:0]           rem2;
   logic                     ge;

   assign a_time  = rd_a[ITEM_W-1:3*VAL_W];
   assign b_time  = rd_b[ITEM_W-1:3*VAL_W];
   assign num     = {t_ff[TIME_W-1], t_ff} - {b_time[TIME_W-1], b_time};
   assign den     = {xi_ff[TIME_W-1], xi_ff} - {b_time[TIME_W-1], b_time};
   assign we      = (cmd.op == DP_WRITE);
   assign wr_data = {t_ff, item_ff};

   assign stat.opcode   = op_ff;
   assign stat.scan_hit = (prev_ff <= t_ff) && (t_ff < a_time);
   assign stat.time_eq  = (a_time == t_ff);
   assign stat.den_zero = (dmag_ff == '0);
   assign stat.sat      = (p_ff >= {1'b0, dmag_ff, 62'd0});

   assign rem2 = {rem_ff, p_ff[61]};
   assign ge   = (rem2 >= {1'b0, dmag_ff});

   always_comb begin
      case (cmd.sel)
         MS_WL_NL, MS_WL_NH, MS_WL_Y0, MS_WL_Y1, MS_WL_Y2: mul_a = w_ff[31:0];
         default: mul_a = {1'b0, w_ff[WGT_W-1:32]};
      endcase
      case (cmd.sel)
         MS_WL_NL, MS_WH_NL: mul_b = nmag_ff[31:0];
         MS_WL_NH, MS_WH_NH: mul_b = {23'd0, nmag_ff[MAG_W-1:32]};
         MS_WL_Y0, MS_WH_Y0: mul_b = yv_ff[0][VAL_W-1] ? VAL_W'(-yv_ff[0]) : yv_ff[0];
         MS_WL_Y1, MS_WH_Y1: mul_b = yv_ff[1][VAL_W-1] ? VAL_W'(-yv_ff[1]) : yv_ff[1];
         default:            mul_b = yv_ff[2][VAL_W-1] ? VAL_W'(-yv_ff[2]) : yv_ff[2];
      endcase
      case (pp_sel_ff)
         MS_WL_Y0, MS_WH_Y0: begin acc_k = 2'd0; is_term = 1'b1; end
         MS_WL_Y1, MS_WH_Y1: begin acc_k = 2'd1; is_term = 1'b1; end
         MS_WL_Y2, MS_WH_Y2: begin acc_k = 2'd2; is_term = 1'b1; end
         default:            begin acc_k = 2'd0; is_term = 1'b0; end
      endcase
   end

   assign pp_sh = shift_of(pp_sel_ff);
   assign term  = ACC_W'(pp_ff) << pp_sh;

   always_comb begin
      w_in   = w_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      p_in   = p_ff;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = acc_ff[k];
      end
      if (pp_vld_ff) begin
         if (is_term) begin
            if (neg_ff ^ yv_ff[acc_k][VAL_W-1]) begin
               acc_in[acc_k] = acc_ff[acc_k] - $signed(term);
            end else begin
               acc_in[acc_k] = acc_ff[acc_k] + $signed(term);
            end
         end else begin
            p_in = p_ff + (PROD_W'(pp_ff) << pp_sh);
         end
      end
      case (cmd.op)
         DP_CAPTURE: begin
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = '0;
            end
         end
         DP_NODE: begin
            w_in   = W_ONE;
            neg_in = 1'b0;
         end
         DP_FACTOR: p_in = '0;
         DP_SATCHK: begin
            neg_in = neg_ff ^ nsign_ff ^ dsign_ff;
            w_in   = stat.sat ? W_MAX : '0;
            rem_in = p_ff[PROD_W-2:62];
         end
         DP_DIV: begin
            rem_in = ge ? MAG_W'(rem2 - {1'b0, dmag_ff}) : rem2[MAG_W-1:0];
            w_in   = {w_ff[WGT_W-2:0], ge};
            p_in   = p_ff << 1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff <= 1'b0;
      end else begin
         pp_vld_ff <= (cmd.op == DP_MUL);
      end
      pp_ff     <= PP_W'(mul_a) * PP_W'(mul_b);
      pp_sel_ff <= cmd.sel;
      w_ff      <= w_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      p_ff      <= p_in;
      for (int k = 0; k < 3; k++) begin
         acc_ff[k] <= acc_in[k];
      end
      case (cmd.op)
         DP_CAPTURE: begin
            op_ff   <= req_tuser;
            t_ff    <= req_tdata[TIME_W-1:0];
            item_ff <= {req_tdata[TIME_W +: VAL_W], req_tdata[TIME_W+VAL_W +: VAL_W],
                        req_tdata[TIME_W+2*VAL_W +: VAL_W]};
         end
         DP_WRITE: begin
            res_status_ff <= ST_STORED;
            res_data_ff   <= '0;
         end
         DP_RES_STATUS: begin
            res_status_ff <= cmd.status;
            res_data_ff   <= '0;
         end
         DP_RES_HELD: begin
            res_status_ff <= ST_HELD;
            res_data_ff   <= {rd_a[VAL_W-1:0], rd_a[2*VAL_W-1:VAL_W],
                              rd_a[3*VAL_W-1:2*VAL_W], a_time};
         end
         DP_RES_MATCH: begin
            res_status_ff <= ST_INTERP;
            res_data_ff   <= {rd_a[VAL_W-1:0], rd_a[2*VAL_W-1:VAL_W],
                              rd_a[3*VAL_W-1:2*VAL_W], t_ff};
         end
         DP_RES_INTERP: begin
            res_status_ff <= ST_INTERP;
            res_data_ff   <= {finish_val(acc_ff[2]), finish_val(acc_ff[1]),
                              finish_val(acc_ff[0]), t_ff};
         end
         DP_SCAN: prev_ff <= a_time;
         DP_NODE: begin
            xi_ff    <= a_time;
            yv_ff[0] <= rd_a[3*VAL_W-1:2*VAL_W];
            yv_ff[1] <= rd_a[2*VAL_W-1:VAL_W];
            yv_ff[2] <= rd_a[VAL_W-1:0];
         end
         DP_FACTOR: begin
            nsign_ff <= num[MAG_W-1];
            dsign_ff <= den[MAG_W-1];
            nmag_ff  <= num[MAG_W-1] ? MAG_W'(-num) : num;
            dmag_ff  <= den[MAG_W-1] ? MAG_W'(-den) : den;
         end
         default: ;
      endcase
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== sv/elip_checker.sv =====
// Port-level checks of the interpolator, bound to the top level.
// Depends on elip_pkg and eop_lagrange_interpolator.
module elip_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [2:0]                  rsp_tuser,
   input logic [elip_pkg::ITEM_W-1:0] rsp_tdata
);
   import elip_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_CLEARED)
      else $error("undefined status code");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_INTERP && rsp_tuser != ST_HELD |-> rsp_tdata == '0)
      else $error("non-query response carries data");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind eop_lagrange_interpolator elip_checker u_elip_checker (.*);

// ===== dv/tb_eop_lagrange_interpolator.sv =====
// Self-checking testbench for the earth-orientation Lagrange interpolator.
// Streams clear/append/query requests, predicts every response in 128-bit fixed point.
// Depends on elip_pkg and eop_lagrange_interpolator.
module tb_eop_lagrange_interpolator;
   timeunit 1ns;
   timeprecision 1ps;
   import elip_pkg::*;

   localparam int DEPTH = 64;
   localparam int HALF = 4;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_QUERY_ALT = 2'd3;
   localparam int N_ITEMS = 1600;
   localparam int IDLE_LIMIT = 200000;
   localparam int QUIET_TAIL = 150;

   typedef struct {
      logic [1:0]  op;
      logic [39:0] t;
      logic [31:0] px, py, ut;
      bit          hold;
   } eop_req_type;

   typedef struct {
      status_type  st;
      logic [39:0] t;
      logic [31:0] px, py, ut;
   } eop_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [ITEM_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2:0] rsp_tuser;
   logic [ITEM_W-1:0] rsp_tdata;

   eop_req_type pend_q[$];
   eop_rsp_type eop_expect_q[$];

   logic signed [39:0] tab_t[DEPTH];
   logic signed [31:0] tab_px[DEPTH], tab_py[DEPTH], tab_ut[DEPTH];
   int tab_n = 0;

   int fails = 0, n_rsp = 0, n_interp = 0, n_held = 0, n_empty = 0, n_full = 0;
   int gap = 0, stall = 0, idle_cycles = 0;

   eop_lagrange_interpolator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] round_sum(input logic [127:0] acc);
      logic [127:0] a;
      a = acc + (128'd1 << 31);
      if (a[127:63] == '0 || a[127:63] == '1) return a[63:32];
      return a[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   function automatic eop_rsp_type interpolate_eop(input eop_req_type it);
      eop_rsp_type r;
      logic signed [39:0] t;
      logic signed [63:0] num, den;
      logic signed [31:0] y;
      logic [63:0] w, an, ad;
      logic [31:0] ay;
      logic [127:0] p, lim, term;
      logic [127:0] acc[3];
      int first, lo, hi;
      bit neg;
      r = '{ST_INTERP, '0, '0, '0, '0};
      t = it.t;
      if (it.op == OP_CLEAR) begin
         tab_n = 0;
         r.st = ST_CLEARED;
         return r;
      end
      if (it.op == OP_APPEND) begin
         if (tab_n < DEPTH) begin
            tab_t[tab_n] = it.t;
            tab_px[tab_n] = it.px;
            tab_py[tab_n] = it.py;
            tab_ut[tab_n] = it.ut;
            tab_n++;
            r.st = ST_STORED;
         end else begin
            r.st = ST_FULL;
         end
         return r;
      end
      if (tab_n == 0) begin
         r.st = ST_EMPTY;
         return r;
      end
      first = -1;
      for (int i = 0; i + 1 < tab_n; i++)
         if (t >= tab_t[i] && t < tab_t[i+1]) first = i;
      if (first < 0) begin
         r.st = ST_HELD;
         r.t = tab_t[tab_n-1];
         r.px = tab_px[tab_n-1];
         r.py = tab_py[tab_n-1];
         r.ut = tab_ut[tab_n-1];
         return r;
      end
      lo = (first - HALF + 1 < 0) ? 0 : first - HALF + 1;
      hi = (first + HALF + 1 > tab_n - 1) ? tab_n - 1 : first + HALF + 1;
      r.t = it.t;
      for (int i = lo; i <= hi; i++)
         if (tab_t[i] == t) begin
            r.px = tab_px[i];
            r.py = tab_py[i];
            r.ut = tab_ut[i];
            return r;
         end
      for (int k = 0; k < 3; k++) acc[k] = '0;
      for (int i = lo; i <= hi; i++) begin
         w = 64'd1 << 32;
         neg = 1'b0;
         for (int j = lo; j <= hi; j++) begin
            if (j == i) continue;
            den = tab_t[i] - tab_t[j];
            if (den == 0) continue;
            num = t - tab_t[j];
            an = num[63] ? -num : num;
            ad = den[63] ? -den : den;
            p = {64'b0, w} * {64'b0, an};
            lim = {64'b0, ad} << 62;
            w = (p >= lim) ? (64'd1 << 62) : 64'(p / {64'b0, ad});
            neg = neg ^ num[63] ^ den[63];
         end
         for (int k = 0; k < 3; k++) begin
            y = (k == 0) ? tab_px[i] : (k == 1) ? tab_py[i] : tab_ut[i];
            ay = y[31] ? (~y + 32'd1) : y;
            term = {64'b0, w} * {96'b0, ay};
            if (neg ^ y[31]) term = -term;
            acc[k] = acc[k] + term;
         end
      end
      r.px = round_sum(acc[0]);
      r.py = round_sum(acc[1]);
      r.ut = round_sum(acc[2]);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      eop_rsp_type e;
      bit nv;
      nv = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            e = interpolate_eop(pend_q[0]);
            case (e.st)
               ST_INTERP: n_interp++;
               ST_HELD:   n_held++;
               ST_EMPTY:  n_empty++;
               ST_FULL:   n_full++;
               default: ;
            endcase
            eop_expect_q.push_back(e);
            void'(pend_q.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            nv = 1'b1;
         end else if (gap > 0) begin
            gap--;
         end else if (pend_q.size() != 0 && !(pend_q[0].hold && eop_expect_q.size() != 0))
         begin
            if (pend_q.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
               gap = $urandom_range(0, 5);
            end else begin
               nv = 1'b1;
               req_tuser <= pend_q[0].op;
               req_tdata <= {pend_q[0].ut, pend_q[0].py, pend_q[0].px, pend_q[0].t};
            end
         end
         req_tvalid <= nv;
      end
   end

   // response monitor
   always @(posedge clock) begin
      eop_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (eop_expect_q.size() == 0) begin
               $error("unexpected response transfer, status %0d", rsp_tuser);
               fails++;
            end else begin
               e = eop_expect_q.pop_front();
               if (rsp_tuser !== e.st) begin
                  $error("status: expected %0d, got %0d", e.st, rsp_tuser); fails++;
               end
               if (rsp_tdata[39:0] !== e.t) begin
                  $error("out_time: expected %h, got %h", e.t, rsp_tdata[39:0]); fails++;
               end
               if (rsp_tdata[71:40] !== e.px) begin
                  $error("out_pole_x: expected %h, got %h", e.px, rsp_tdata[71:40]); fails++;
               end
               if (rsp_tdata[103:72] !== e.py) begin
                  $error("out_pole_y: expected %h, got %h", e.py, rsp_tdata[103:72]); fails++;
               end
               if (rsp_tdata[135:104] !== e.ut) begin
                  $error("out_ut1_offset: expected %h, got %h", e.ut, rsp_tdata[135:104]);
                  fails++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (pend_q.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   int n_pushed = 0;
   logic signed [39:0] gen_t[$];

   task automatic push_item(input logic [1:0] op, input logic [39:0] t,
                            input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] ut, input bit hold);
      eop_req_type it;
      it = '{op, t, px, py, ut, hold};
      pend_q.push_back(it);
      n_pushed++;
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'($signed($urandom_range(0, 2000)) - 1000);
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic build_table(input int n);
      logic signed [39:0] t;
      push_item(OP_CLEAR, 40'({$urandom, $urandom}), $urandom, $urandom, $urandom, 1'b0);
      gen_t.delete();
      t = ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
          40'($signed($urandom_range(0, 200000)) - 100000);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 29) == 0) t = 40'({$urandom, $urandom});
         else if (i > 0 && $urandom_range(0, 14) != 0)
            t = t + $urandom_range(1, 1 << $urandom_range(0, 20));
         gen_t.push_back(t);
         push_item(OP_APPEND, t, rand_val(), rand_val(), rand_val(), 1'b0);
      end
   endtask

   task automatic push_query();
      logic signed [39:0] q;
      logic [39:0] span;
      int n, i;
      n = gen_t.size();
      q = 40'({$urandom, $urandom});
      if (n > 0) begin
         case ($urandom_range(0, 7))
            0: q = gen_t[$urandom_range(0, n - 1)];
            1: q = gen_t[0] - $urandom_range(1, 1000);
            2: q = gen_t[n-1] + $urandom_range(0, 1000);
            3: ;
            default: if (n > 1) begin
               i = $urandom_range(0, n - 2);
               span = gen_t[i+1] - gen_t[i];
               q = gen_t[i];
               if (span > 1) q = gen_t[i] + 40'({$urandom, $urandom} % span);
            end
         endcase
      end
      push_item(($urandom_range(0, 7) == 0) ? OP_QUERY_ALT : OP_QUERY, q,
                $urandom, $urandom, $urandom, $urandom_range(0, 49) == 0);
   endtask

   initial begin
      int n, nq;
      // directed: empty table, extremes, held and exact-node cases, duplicates
      push_item(OP_QUERY, 40'd0, '0, '0, '0, 1'b0);
      push_item(OP_QUERY_ALT, 40'h7F_FFFF_FFFF, '1, '1, '1, 1'b0);
      push_item(OP_APPEND, 40'h80_0000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 1'b0);
      push_item(OP_QUERY, 40'd5, '0, '0, '0, 1'b0);
      push_item(OP_APPEND, 40'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      push_item(OP_APPEND, 40'h7F_FFFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0);
      push_item(OP_QUERY, 40'd1, '0, '0, '0, 1'b0);
      push_item(OP_QUERY, 40'hC0_0000_0000, '0, '0, '0, 1'b0);
      push_item(OP_QUERY, 40'd0, '0, '0, '0, 1'b0);
      push_item(OP_QUERY, 40'h80_0000_0000, '0, '0, '0, 1'b0);
      push_item(OP_QUERY, 40'h7F_FFFF_FFFF, '0, '0, '0, 1'b1);
      push_item(OP_QUERY_ALT, 40'h80_0000_0000 - 1, '0, '0, '0, 1'b0);
      push_item(OP_CLEAR, '0, '0, '0, '0, 1'b0);
      push_item(OP_APPEND, 40'd10, 32'd100, 32'd200, 32'd300, 1'b0);
      push_item(OP_APPEND, 40'd10, 32'd400, 32'd500, 32'd600, 1'b0);
      push_item(OP_APPEND, 40'd20, 32'd700, 32'hFFFF_FF00, 32'd900, 1'b0);
      push_item(OP_QUERY, 40'd15, '0, '0, '0, 1'b0);
      push_item(OP_QUERY, 40'd10, '0, '0, '0, 1'b0);
      push_item(OP_QUERY, 40'd20, '0, '0, '0, 1'b0);
      // full table with overflow, then a full-window query
      build_table(DEPTH + 2);
      push_query();
      push_item(OP_QUERY, gen_t[30] + 1, '0, '0, '0, 1'b0);
      while (n_pushed < N_ITEMS) begin
         if ($urandom_range(0, 39) == 0) begin
            n = $urandom_range(10, DEPTH + 4);
            nq = 2;
         end else begin
            n = $urandom_range(0, 4);
            nq = $urandom_range(1, 4);
         end
         if ($urandom_range(0, 19) == 0) push_query();
         build_table(n);
         repeat (nq) push_query();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pend_q.size() != 0 || eop_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d requests, %0d responses checked: %0d interpolated, %0d held last,",
               n_pushed, n_rsp, n_interp, n_held);
      $display("%0d empty-table queries, %0d appends dropped on a full table.",
               n_empty, n_full);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/elip_pkg.sv
sv/elip_ram.sv
sv/elip_ctrl.sv
sv/elip_dp.sv
sv/eop_lagrange_interpolator.sv
sv/elip_checker.sv
dv/tb_eop_lagrange_interpolator.sv
